// File: hw/rtl/iepe_pkg.sv
// ----------------------------------------------------------------------------
// iepe_pkg
// Shared types, character codes, status codes and controller/datapath
// command and status groups of the infix expression parse and evaluate unit.
// ----------------------------------------------------------------------------
package iepe_pkg;

    // default longest token, in characters
    localparam int TOKEN_MAX_DEF = 31;

    // operand width and divider iteration count
    localparam int DATA_W    = 32;
    localparam int DIV_STEPS = DATA_W;

    // character codes
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // result status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_PARSE  = 3'd1;
    localparam logic [2:0] ST_DIVZ   = 3'd2;
    localparam logic [2:0] ST_MODZ   = 3'd3;
    localparam logic [2:0] ST_UNK_OP = 3'd4;

    // one input transaction
    typedef struct packed {
        logic [7:0] char_code;
        logic       line_end;
    } in_item_t;

    // one result transaction
    typedef struct packed {
        logic [2:0]               status;
        logic signed [DATA_W-1:0] value;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic consume;   // take the input character into the parse state
        logic eval;      // evaluate the parsed line and clear the parse state
        logic div_step;  // one restoring division iteration
        logic div_fin;   // sign-correct the quotient or remainder
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic blank_line; // no content on the line being evaluated
        logic need_div;   // line needs the iterative divider
    } dp_status_t;

endpackage

// File: hw/rtl/iepe_stream_if.sv
// ----------------------------------------------------------------------------
// iepe_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface iepe_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

// File: hw/rtl/iepe_datapath.sv
// ----------------------------------------------------------------------------
// iepe_datapath
// Per-character parse state, operand evaluation, 32-step restoring divider
// and the result register.
// ----------------------------------------------------------------------------
module iepe_datapath #(
    parameter int TOKEN_MAX = iepe_pkg::TOKEN_MAX_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  iepe_pkg::dp_cmd_t                 cmd,
    input  logic [7:0]                        char_code,
    output iepe_pkg::dp_status_t              status,
    output logic [2:0]                        res_status,
    output logic signed [iepe_pkg::DATA_W-1:0] res_value
);
    import iepe_pkg::*;

    localparam int CNT_W = $clog2(TOKEN_MAX + 1);
    localparam logic [CNT_W-1:0] TOK_LIM = CNT_W'(TOKEN_MAX);

    // parse phase codes
    localparam logic [2:0] PH_LEAD   = 3'd0;
    localparam logic [2:0] PH_LEFT   = 3'd1;
    localparam logic [2:0] PH_OPWAIT = 3'd2;
    localparam logic [2:0] PH_RWAIT  = 3'd3;
    localparam logic [2:0] PH_RIGHT  = 3'd4;
    localparam logic [2:0] PH_TAIL   = 3'd5;

    // parse state
    logic [2:0]        phase_reg,      phase_next;
    logic [DATA_W-1:0] lval_reg,       lval_next;
    logic [CNT_W-1:0]  lcnt_reg,       lcnt_next;
    logic [7:0]        op_reg,         op_next;
    logic [DATA_W-1:0] rval_reg,       rval_next;
    logic [CNT_W-1:0]  rcnt_reg,       rcnt_next;
    logic              rneg_reg,       rneg_next;
    logic              rdig_reg,       rdig_next;
    logic              err_reg,        err_next;
    logic              content_reg,    content_next;

    // divider and result
    logic [DATA_W-1:0] rem_reg,  rem_next;
    logic [DATA_W-1:0] quo_reg,  quo_next;
    logic [DATA_W-1:0] dvs_reg,  dvs_next;
    logic              negq_reg, negq_next;
    logic              negr_reg, negr_next;
    logic              ismod_reg, ismod_next;
    logic [2:0]        rst_reg,  rst_next;
    logic [DATA_W-1:0] rval_out_reg, rval_out_next;

    // character classes
    logic              is_blank;
    logic              is_op;
    logic              is_digit;
    logic [2:0]        ph_eff;
    logic [DATA_W-1:0] lval_x10;
    logic [DATA_W-1:0] rval_x10;

    // evaluation terms
    logic              parse_bad;
    logic [DATA_W-1:0] opa;
    logic [DATA_W-1:0] opb;
    logic [DATA_W-1:0] ua;
    logic [DATA_W-1:0] ub;
    logic [DATA_W-1:0] prod;
    logic [2:0]        ev_status;
    logic [DATA_W-1:0] ev_value;
    logic              ev_div;

    // divider step terms
    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   rem_diff;

    assign is_blank = (char_code == CH_SPACE) || (char_code == CH_TAB) ||
                      (char_code == CH_LF) || (char_code == CH_CR);
    assign is_op    = (char_code == CH_PLUS) || (char_code == CH_MINUS) ||
                      (char_code == CH_STAR) || (char_code == CH_SLASH) ||
                      (char_code == CH_PCT);
    assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);

    // v * 10 + digit as shift-add, wrapping at 32 bits
    assign lval_x10 = {lval_reg[DATA_W-4:0], 3'b000} + {lval_reg[DATA_W-2:0], 1'b0} +
                      {{(DATA_W-4){1'b0}}, char_code[3:0]};
    assign rval_x10 = {rval_reg[DATA_W-4:0], 3'b000} + {rval_reg[DATA_W-2:0], 1'b0} +
                      {{(DATA_W-4){1'b0}}, char_code[3:0]};

    // phase after leading-space or right-wait fall-through
    always_comb
    begin
        ph_eff = phase_reg;
        if ((phase_reg == PH_LEAD) && !is_blank)
        begin
            ph_eff = PH_LEFT;
        end
        else if ((phase_reg == PH_RWAIT) && !is_blank)
        begin
            ph_eff = PH_RIGHT;
        end
    end

    // operand evaluation
    assign parse_bad = err_reg || (phase_reg < PH_RWAIT) ||
                       (lcnt_reg == '0) || !rdig_reg;
    assign opa  = lval_reg;
    assign opb  = rneg_reg ? (DATA_W'(0) - rval_reg) : rval_reg;
    assign ua   = opa[DATA_W-1] ? (DATA_W'(0) - opa) : opa;
    assign ub   = opb[DATA_W-1] ? (DATA_W'(0) - opb) : opb;
    assign prod = DATA_W'(opa * opb);

    always_comb
    begin
        ev_status = ST_OK;
        ev_value  = '0;
        ev_div    = 1'b0;
        if (parse_bad)
        begin
            ev_status = ST_PARSE;
        end
        else
        begin
            case (op_reg)
                CH_PLUS:  ev_value = opa + opb;
                CH_MINUS: ev_value = opa - opb;
                CH_STAR:  ev_value = prod;
                CH_SLASH:
                begin
                    if (opb == '0)
                    begin
                        ev_status = ST_DIVZ;
                    end
                    else
                    begin
                        ev_div = 1'b1;
                    end
                end
                CH_PCT:
                begin
                    if (opb == '0)
                    begin
                        ev_status = ST_MODZ;
                    end
                    else
                    begin
                        ev_div = 1'b1;
                    end
                end
                default:  ev_status = ST_UNK_OP;
            endcase
        end
    end

    assign status.blank_line = !content_reg;
    assign status.need_div   = ev_div;

    // restoring division step
    assign rem_sh   = {rem_reg, quo_reg[DATA_W-1]};
    assign rem_diff = rem_sh - {1'b0, dvs_reg};

    // next-state logic
    always_comb
    begin
        phase_next    = phase_reg;
        lval_next     = lval_reg;
        lcnt_next     = lcnt_reg;
        op_next       = op_reg;
        rval_next     = rval_reg;
        rcnt_next     = rcnt_reg;
        rneg_next     = rneg_reg;
        rdig_next     = rdig_reg;
        err_next      = err_reg;
        content_next  = content_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        dvs_next      = dvs_reg;
        negq_next     = negq_reg;
        negr_next     = negr_reg;
        ismod_next    = ismod_reg;
        rst_next      = rst_reg;
        rval_out_next = rval_out_reg;

        // parse one character
        if (cmd.consume)
        begin
            if ((phase_reg == PH_LEAD) && !is_blank)
            begin
                content_next = 1'b1;
            end
            case (ph_eff)
                PH_LEAD: ;
                PH_LEFT:
                begin
                    phase_next = PH_LEFT;
                    if (is_blank)
                    begin
                        phase_next = PH_OPWAIT;
                    end
                    else if (is_op)
                    begin
                        op_next    = char_code;
                        phase_next = PH_RWAIT;
                    end
                    else if (lcnt_reg >= TOK_LIM)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        lcnt_next = lcnt_reg + 1'b1;
                        if (!is_digit)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            lval_next = lval_x10;
                        end
                    end
                end
                PH_OPWAIT:
                begin
                    if (!is_blank)
                    begin
                        op_next    = char_code;
                        phase_next = PH_RWAIT;
                    end
                end
                PH_RWAIT: ;
                PH_RIGHT:
                begin
                    phase_next = PH_RIGHT;
                    if (is_blank)
                    begin
                        phase_next = PH_TAIL;
                    end
                    else if (rcnt_reg >= TOK_LIM)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        if ((rcnt_reg == '0) && (char_code == CH_MINUS))
                        begin
                            rneg_next = 1'b1;
                        end
                        else if ((rcnt_reg == '0) && (char_code == CH_PLUS))
                        begin
                            rneg_next = rneg_reg;
                        end
                        else if (!is_digit)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            rval_next = rval_x10;
                            rdig_next = 1'b1;
                        end
                        rcnt_next = rcnt_reg + 1'b1;
                    end
                end
                default:
                begin
                    // trailing space and unused codes
                    if (!is_blank)
                    begin
                        err_next = 1'b1;
                    end
                end
            endcase
        end

        // evaluate the line, load the divider, clear the parse state
        if (cmd.eval)
        begin
            rst_next      = ev_status;
            rval_out_next = ev_value;
            rem_next      = '0;
            quo_next      = ua;
            dvs_next      = ub;
            negq_next     = opa[DATA_W-1] ^ opb[DATA_W-1];
            negr_next     = opa[DATA_W-1];
            ismod_next    = (op_reg == CH_PCT);
            phase_next    = PH_LEAD;
            lval_next     = '0;
            lcnt_next     = '0;
            op_next       = '0;
            rval_next     = '0;
            rcnt_next     = '0;
            rneg_next     = 1'b0;
            rdig_next     = 1'b0;
            err_next      = 1'b0;
            content_next  = 1'b0;
        end

        // one quotient bit
        if (cmd.div_step)
        begin
            if (!rem_diff[DATA_W])
            begin
                rem_next = rem_diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
        end

        // signed result of the division
        if (cmd.div_fin)
        begin
            if (ismod_reg)
            begin
                rval_out_next = negr_reg ? (DATA_W'(0) - rem_reg) : rem_reg;
            end
            else
            begin
                rval_out_next = negq_reg ? (DATA_W'(0) - quo_reg) : quo_reg;
            end
        end
    end

    // parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_LEAD;
            lval_reg    <= '0;
            lcnt_reg    <= '0;
            op_reg      <= '0;
            rval_reg    <= '0;
            rcnt_reg    <= '0;
            rneg_reg    <= 1'b0;
            rdig_reg    <= 1'b0;
            err_reg     <= 1'b0;
            content_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            lval_reg    <= lval_next;
            lcnt_reg    <= lcnt_next;
            op_reg      <= op_next;
            rval_reg    <= rval_next;
            rcnt_reg    <= rcnt_next;
            rneg_reg    <= rneg_next;
            rdig_reg    <= rdig_next;
            err_reg     <= err_next;
            content_reg <= content_next;
        end
    end

    // divider and result registers
    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        dvs_reg      <= dvs_next;
        negq_reg     <= negq_next;
        negr_reg     <= negr_next;
        ismod_reg    <= ismod_next;
        rst_reg      <= rst_next;
        rval_out_reg <= rval_out_next;
    end

    assign res_status = rst_reg;
    assign res_value  = rval_out_reg;

endmodule

// File: hw/rtl/iepe_ctrl.sv
// ----------------------------------------------------------------------------
// iepe_ctrl
// Controller: accepts characters, sequences evaluation and division, and
// holds the result until it is taken.
// ----------------------------------------------------------------------------
module iepe_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_line_end,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  iepe_pkg::dp_status_t status,
    output iepe_pkg::dp_cmd_t    cmd
);
    import iepe_pkg::*;

    localparam int STEP_W = $clog2(DIV_STEPS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

    // state codes
    localparam logic [2:0] S_RUN  = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg,  step_next;
    logic              in_fire;

    assign in_ready  = (state_reg == S_RUN);
    assign out_valid = (state_reg == S_OUT);
    assign in_fire   = in_valid && in_ready;

    // commands to the datapath
    assign cmd.consume  = in_fire;
    assign cmd.eval     = (state_reg == S_EVAL);
    assign cmd.div_step = (state_reg == S_DIV);
    assign cmd.div_fin  = (state_reg == S_FIN);

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            S_RUN:
            begin
                if (in_fire && in_line_end)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                step_next = '0;
                if (status.blank_line)
                begin
                    state_next = S_RUN;
                end
                else if (status.need_div)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_DIV:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_RUN;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RUN;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// File: hw/rtl/infix_expression_parse_eval_unit.sv
// ----------------------------------------------------------------------------
// infix_expression_parse_eval_unit
// Parses one text line of the form "left op right", one character per
// transaction, and returns one status/value result per non-blank line.
// ----------------------------------------------------------------------------
// Characters are taken one per cycle while the line is being read. After
// the character marked as line end the input stalls: a blank line returns to
// reading with no result, +, - and * are evaluated straight into the result
// register, and / and % pass through evaluation, 32 iterations of the
// restoring divider and sign correction. The result then sits in the output
// register until taken; the next line is accepted only after that.
module infix_expression_parse_eval_unit #(
    parameter int TOKEN_MAX = iepe_pkg::TOKEN_MAX_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    iepe_stream_if.sink   in_ch,
    iepe_stream_if.source out_ch
);
    import iepe_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic [2:0]               res_status;
    logic signed [DATA_W-1:0] res_value;

    // controller
    iepe_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_ch.valid),
        .in_line_end (in_ch.payload.line_end),
        .in_ready    (in_ch.ready),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .status      (status),
        .cmd         (cmd)
    );

    // datapath
    iepe_datapath #(
        .TOKEN_MAX (TOKEN_MAX)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .char_code  (in_ch.payload.char_code),
        .status     (status),
        .res_status (res_status),
        .res_value  (res_value)
    );

    assign out_ch.payload.status = res_status;
    assign out_ch.payload.value  = res_value;

endmodule
